>>> hw/rtl/torus_vertex_generator_macros.svh
// assertion macros for the torus vertex generator
// used by the top level only, no other dependencies
`ifndef TORUS_VERTEX_GENERATOR_MACROS_SVH
`define TORUS_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define TVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TVG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tvg_pkg.sv
// shared types, constants and helper functions of the torus vertex generator
// no dependencies
package tvg_pkg;

    localparam int IDX_W      = 13;
    localparam int RAD_W      = 16;
    localparam int STEP_REG_W = 13;
    localparam int POS_W      = 18;
    localparam int NRM_W      = 16;
    localparam int TEX_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = 24;
    localparam int CW         = 33;
    localparam int TAB_LEN    = 24;

    localparam int DEF_MAX_STEPS     = 4096;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_STEPS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_STEPS  = 2'd3;

    localparam logic [RAD_W-1:0]      RST_MAJOR_RADIUS = 16'd256;
    localparam logic [RAD_W-1:0]      RST_MINOR_RADIUS = 16'd64;
    localparam logic [STEP_REG_W-1:0] RST_MAJOR_STEPS  = 13'd32;
    localparam logic [STEP_REG_W-1:0] RST_MINOR_STEPS  = 13'd16;

    localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [CW-1:0]    t_cw;
    typedef logic signed [NRM_W-1:0] t_q14;
    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [TEX_W-1:0]        t_tex;

    typedef struct packed {
        t_cw x;
        t_cw y;
        t_cw z;
    } t_rot;

    // cordic start vector, gain 0.6072529350 in q1.30
    localparam t_cw GAIN_Q30 = 33'sd652032874;

    // atan(2^-i) as a fraction of a full turn, q0.32
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic t_q14 sat_q14(input logic signed [35:0] v);
        if (v < -36'sd16384) begin
            return -16'sd16384;
        end
        if (v > 36'sd16384) begin
            return 16'sd16384;
        end
        return t_q14'(v[NRM_W-1:0]);
    endfunction

    function automatic t_pos sat_pos(input logic signed [35:0] v);
        if (v < -36'sd131072) begin
            return -18'sd131072;
        end
        if (v > 36'sd131071) begin
            return 18'sd131071;
        end
        return t_pos'(v[POS_W-1:0]);
    endfunction

    // q1.30 to q1.14, round to nearest, saturate
    function automatic t_q14 q14_from_q30(input t_cw v);
        logic signed [CW:0] s;
        s = (CW+1)'(v) + ((CW+1)'(1) <<< 15);
        return sat_q14(36'(s >>> 16));
    endfunction

endpackage

>>> hw/rtl/tvg_in_if.sv
// input channel of the torus vertex generator: one grid point per transaction
// depends on tvg_pkg
interface tvg_in_if import tvg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] major_index;
    logic [IDX_W-1:0] minor_index;
    logic             half_offset;

    modport source(output valid, major_index, minor_index, half_offset, input ready);
    modport sink(input valid, major_index, minor_index, half_offset, output ready);
endinterface

>>> hw/rtl/tvg_out_if.sv
// output channel of the torus vertex generator: one vertex per transaction
// depends on tvg_pkg
interface tvg_out_if import tvg_pkg::*; ();
    logic valid;
    logic ready;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;
    t_q14 normal_x;
    t_q14 normal_y;
    t_q14 normal_z;
    t_q14 tangent_x;
    t_q14 tangent_z;
    t_tex tex_s;
    t_tex tex_t;
    logic on_seam;

    modport source(output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                   tangent_x, tangent_z, tex_s, tex_t, on_seam, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                 tangent_x, tangent_z, tex_s, tex_t, on_seam, output ready);
endinterface

>>> hw/rtl/tvg_div_cell.sv
// one restoring division step for two lanes, registered, with sideband
// depends on tvg_pkg
module tvg_div_cell import tvg_pkg::*; #(
    parameter int DW = 14,
    parameter int PW = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0][DW-1:0]         i_rem,
    input  logic [1:0][DW-1:0]         i_den,
    input  logic [1:0][QUO_W-1:0]      i_quo,
    input  logic [PW-1:0]              i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0][DW-1:0]         o_rem,
    output logic [1:0][DW-1:0]         o_den,
    output logic [1:0][QUO_W-1:0]      o_quo,
    output logic [PW-1:0]              o_side
);
    logic                  r_valid;
    logic [1:0][DW-1:0]    r_rem, n_rem;
    logic [1:0][DW-1:0]    r_den;
    logic [1:0][QUO_W-1:0] r_quo, n_quo;
    logic [PW-1:0]         r_side;

    always_comb begin
        logic [DW:0] v_trial;
        logic        v_ge;
        for (int k = 0; k < 2; k++) begin
            v_trial  = {i_rem[k], 1'b0};
            v_ge     = (v_trial >= {1'b0, i_den[k]});
            n_rem[k] = v_ge ? DW'(v_trial - {1'b0, i_den[k]}) : DW'(v_trial);
            n_quo[k] = {i_quo[k][QUO_W-2:0], v_ge};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

>>> hw/rtl/tvg_cordic_cell.sv
// one cordic rotation stage for two lanes, registered, with sideband
// depends on tvg_pkg
module tvg_cordic_cell import tvg_pkg::*; #(
    parameter int STAGE = 0,
    parameter int PW    = 39
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_rot [1:0]      i_rot,
    input  logic [PW-1:0]   i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output t_rot [1:0]      o_rot,
    output logic [PW-1:0]   o_side
);
    localparam t_cw ATAN = t_cw'({1'b0, atan_turn(STAGE)});

    logic          r_valid;
    t_rot [1:0]    r_rot, n_rot;
    logic [PW-1:0] r_side;

    always_comb begin
        t_cw v_dx;
        t_cw v_dy;
        for (int k = 0; k < 2; k++) begin
            v_dx = i_rot[k].y >>> STAGE;
            v_dy = i_rot[k].x >>> STAGE;
            if (!i_rot[k].z[CW-1]) begin
                n_rot[k].x = i_rot[k].x - v_dx;
                n_rot[k].y = i_rot[k].y + v_dy;
                n_rot[k].z = i_rot[k].z - ATAN;
            end else begin
                n_rot[k].x = i_rot[k].x + v_dx;
                n_rot[k].y = i_rot[k].y - v_dy;
                n_rot[k].z = i_rot[k].z + ATAN;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rot  <= n_rot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_side  = r_side;
endmodule

>>> hw/rtl/torus_vertex_generator.sv
// torus vertex generator, top level
// depends on tvg_pkg, tvg_in_if, tvg_out_if, tvg_div_cell, tvg_cordic_cell
// and the assertion macros in torus_vertex_generator_macros.svh
//
// one grid point (major, minor, half step flag) in, one vertex out: position
// in q17.0, unit normal and ring tangent in q1.14, texcoords with 65536 as 1.0
// and a seam flag. the block takes one transaction per clock while the output
// is not stalled, and holds at most one point per stage in flight (44 with sixteen
// cordic stages); there is no state between points. the stages are
// a clamp stage, a chain of 24 division cells that builds the q0.24 angle
// fraction one quotient bit per cell, a chain of cordic cells with one
// rotation per cell, a quadrant and rounding stage, and two multiply stages,
// the last of which is the output register. every stage has its own valid bit
// and takes new data whenever it is empty or its successor moves, so bubbles
// close up and new points keep entering while a finished vertex waits at the
// output, until every stage is full. both angles go down the same cells side
// by side in two lanes.
// step counts of zero read as one, counts above MAX_STEPS as MAX_STEPS;
// indices clamp to the step count and an index equal to it wraps to zero for
// geometry while its texcoord reads 1.0. configuration is written through a
// plain write port and must only change while no point is in flight.
`include "torus_vertex_generator_macros.svh"
module torus_vertex_generator import tvg_pkg::*; #(
    parameter int MAX_STEPS     = DEF_MAX_STEPS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tvg_in_if.sink                i_in,
    tvg_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SW      = $clog2(MAX_STEPS + 1);
    localparam int DW      = SW + 1;
    localparam int DSIDE_W = 3;
    localparam int CSIDE_W = 2 * 2 + 2 * TEX_W + 1;

    // configuration registers
    logic [RAD_W-1:0]      r_major_radius;
    logic [RAD_W-1:0]      r_minor_radius;
    logic [STEP_REG_W-1:0] r_major_steps;
    logic [STEP_REG_W-1:0] r_minor_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_radius <= RST_MAJOR_RADIUS;
            r_minor_radius <= RST_MINOR_RADIUS;
            r_major_steps  <= RST_MAJOR_STEPS;
            r_minor_steps  <= RST_MINOR_STEPS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAJOR_RADIUS: r_major_radius <= i_cfg_data;
                CFG_MINOR_RADIUS: r_minor_radius <= i_cfg_data;
                CFG_MAJOR_STEPS:  r_major_steps  <= i_cfg_data[STEP_REG_W-1:0];
                CFG_MINOR_STEPS:  r_minor_steps  <= i_cfg_data[STEP_REG_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // clamp stage: effective step counts, clamped and wrapped indices
    // ---------------------------------------------------------------
    logic [1:0][SW-1:0]  w_steps;
    logic [1:0][SW-1:0]  w_idx;
    logic [1:0]          w_at_seam;
    logic [1:0][DW-1:0]  n_num_f, n_den_f;

    always_comb begin
        logic [STEP_REG_W-1:0] v_reg;
        logic [IDX_W-1:0]      v_in;
        for (int k = 0; k < 2; k++) begin
            v_reg = (k == 0) ? r_major_steps : r_minor_steps;
            v_in  = (k == 0) ? i_in.major_index : i_in.minor_index;
            // zero steps read as one, too many clamp to the maximum
            if (v_reg == '0) begin
                w_steps[k] = SW'(1);
            end else if (32'(v_reg) > 32'(MAX_STEPS)) begin
                w_steps[k] = SW'(MAX_STEPS);
            end else begin
                w_steps[k] = SW'(v_reg);
            end
            w_idx[k]     = (32'(v_in) > 32'(w_steps[k])) ? w_steps[k] : SW'(v_in);
            w_at_seam[k] = (w_idx[k] == w_steps[k]);
            // geometry wraps the seam index to zero
            n_num_f[k]   = {(w_at_seam[k] ? SW'(0) : w_idx[k]), i_in.half_offset};
            n_den_f[k]   = {w_steps[k], 1'b0};
        end
    end

    logic                r_vld_f;
    logic [1:0][DW-1:0]  r_num_f, r_den_f;
    logic [DSIDE_W-1:0]  r_side_f;

    // division chain wiring, index 0 is the clamp stage
    logic [QUO_W:0]               w_dvld, w_drdy;
    logic [1:0][DW-1:0]           w_drem [0:QUO_W];
    logic [1:0][DW-1:0]           w_dden [0:QUO_W];
    logic [1:0][QUO_W-1:0]        w_dquo [0:QUO_W];
    logic [DSIDE_W-1:0]           w_dside[0:QUO_W];

    assign i_in.ready = !r_vld_f || w_drdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
        end else if (i_in.ready) begin
            r_vld_f <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_num_f  <= n_num_f;
            r_den_f  <= n_den_f;
            // seam flag, texcoord saturation per axis
            r_side_f <= {(w_at_seam[0] || w_at_seam[1]), w_at_seam[1], w_at_seam[0]};
        end
    end

    assign w_dvld[0]  = r_vld_f;
    assign w_drem[0]  = r_num_f;
    assign w_dden[0]  = r_den_f;
    assign w_dquo[0]  = '0;
    assign w_dside[0] = r_side_f;

    // ---------------------------------------------------------------
    // division chain: one quotient bit per cell, numerator below divisor
    // ---------------------------------------------------------------
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        tvg_div_cell #(
            .DW (DW),
            .PW (DSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dvld[g]),
            .o_ready (w_drdy[g]),
            .i_rem   (w_drem[g]),
            .i_den   (w_dden[g]),
            .i_quo   (w_dquo[g]),
            .i_side  (w_dside[g]),
            .o_valid (w_dvld[g+1]),
            .i_ready (w_drdy[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_den   (w_dden[g+1]),
            .o_quo   (w_dquo[g+1]),
            .o_side  (w_dside[g+1])
        );
    end

    // ---------------------------------------------------------------
    // cordic setup: first-quadrant angle in q0.32, quadrant and texcoords
    // ---------------------------------------------------------------
    logic [CORDIC_STAGES:0] w_cvld, w_crdy;
    t_rot [1:0]             w_crot [0:CORDIC_STAGES];
    logic [CSIDE_W-1:0]     w_cside[0:CORDIC_STAGES];
    logic [1:0][1:0]        w_quad;
    t_tex [1:0]             w_tex;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_crot[0][k].x = GAIN_Q30;
            w_crot[0][k].y = '0;
            w_crot[0][k].z = t_cw'({3'b000, w_dquo[QUO_W][k][QUO_W-3:0], 8'h00});
            w_quad[k]      = w_dquo[QUO_W][k][QUO_W-1:QUO_W-2];
            // texcoord is the top of the same fraction, 1.0 at the seam
            w_tex[k]       = w_dside[QUO_W][k] ? TEX_ONE
                                               : TEX_W'(w_dquo[QUO_W][k][QUO_W-1:8]);
        end
    end

    assign w_cvld[0]       = w_dvld[QUO_W];
    assign w_drdy[QUO_W]   = w_crdy[0];
    assign w_cside[0]      = {w_dside[QUO_W][2], w_tex[1], w_tex[0], w_quad[1], w_quad[0]};

    // ---------------------------------------------------------------
    // cordic chain: one rotation per cell, theta in lane 0, phi in lane 1
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        tvg_cordic_cell #(
            .STAGE (g),
            .PW    (CSIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cvld[g]),
            .o_ready (w_crdy[g]),
            .i_rot   (w_crot[g]),
            .i_side  (w_cside[g]),
            .o_valid (w_cvld[g+1]),
            .i_ready (w_crdy[g+1]),
            .o_rot   (w_crot[g+1]),
            .o_side  (w_cside[g+1])
        );
    end

    // ---------------------------------------------------------------
    // quadrant fold and rounding to q1.14
    // ---------------------------------------------------------------
    logic                r_vld_rd, w_rdy_rd, w_rdy_m1;
    t_q14 [1:0]          n_cos, n_sin, r_cos, r_sin;
    t_tex                r_ta_rd, r_tb_rd;
    logic                r_seam_rd;

    always_comb begin
        t_cw v_xc;
        t_cw v_yc;
        for (int k = 0; k < 2; k++) begin
            unique case (w_cside[CORDIC_STAGES][2*k +: 2])
                QUAD_0: begin
                    v_xc = w_crot[CORDIC_STAGES][k].x;
                    v_yc = w_crot[CORDIC_STAGES][k].y;
                end
                QUAD_1: begin
                    v_xc = -w_crot[CORDIC_STAGES][k].y;
                    v_yc = w_crot[CORDIC_STAGES][k].x;
                end
                QUAD_2: begin
                    v_xc = -w_crot[CORDIC_STAGES][k].x;
                    v_yc = -w_crot[CORDIC_STAGES][k].y;
                end
                QUAD_3: begin
                    v_xc = w_crot[CORDIC_STAGES][k].y;
                    v_yc = -w_crot[CORDIC_STAGES][k].x;
                end
            endcase
            n_cos[k] = q14_from_q30(v_xc);
            n_sin[k] = q14_from_q30(v_yc);
        end
    end

    assign w_rdy_rd              = !r_vld_rd || w_rdy_m1;
    assign w_crdy[CORDIC_STAGES] = w_rdy_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_rd <= 1'b0;
        end else if (w_rdy_rd) begin
            r_vld_rd <= w_cvld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cvld[CORDIC_STAGES] && w_rdy_rd) begin
            r_cos     <= n_cos;
            r_sin     <= n_sin;
            r_ta_rd   <= w_cside[CORDIC_STAGES][4 +: TEX_W];
            r_tb_rd   <= w_cside[CORDIC_STAGES][4 + TEX_W +: TEX_W];
            r_seam_rd <= w_cside[CORDIC_STAGES][CSIDE_W-1];
        end
    end

    // ---------------------------------------------------------------
    // first multiply stage: ring distance, tube height, normal products
    // ---------------------------------------------------------------
    logic                     r_vld_m1, w_rdy_m2;
    logic signed [RAD_W:0]    w_r_s;
    logic signed [RAD_W+NRM_W:0] w_rcp, w_rsp;
    logic signed [RAD_W+NRM_W+1:0] n_a;
    logic signed [2*NRM_W-2:0] w_ncx, w_ncz;

    logic signed [RAD_W+NRM_W+1:0] r_a;
    logic signed [RAD_W+NRM_W:0]   r_pyp;
    logic signed [2*NRM_W-2:0]     r_ncx, r_ncz;
    t_q14                          r_ct_m1, r_st_m1, r_sp_m1;
    t_tex                          r_ta_m1, r_tb_m1;
    logic                          r_seam_m1;

    assign w_r_s = $signed({1'b0, r_minor_radius});
    assign w_rcp = w_r_s * r_cos[1];
    assign w_rsp = w_r_s * r_sin[1];
    // major radius scaled to q.14 plus r cos phi
    assign n_a   = $signed({4'b0000, r_major_radius, 14'h0000})
                 + (RAD_W+NRM_W+2)'(w_rcp);
    assign w_ncx = r_cos[1] * r_cos[0];
    assign w_ncz = r_cos[1] * r_sin[0];

    assign w_rdy_m1 = !r_vld_m1 || w_rdy_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m1 <= 1'b0;
        end else if (w_rdy_m1) begin
            r_vld_m1 <= r_vld_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld_rd && w_rdy_m1) begin
            r_a       <= n_a;
            r_pyp     <= w_rsp;
            r_ncx     <= w_ncx;
            r_ncz     <= w_ncz;
            r_ct_m1   <= r_cos[0];
            r_st_m1   <= r_sin[0];
            r_sp_m1   <= r_sin[1];
            r_ta_m1   <= r_ta_rd;
            r_tb_m1   <= r_tb_rd;
            r_seam_m1 <= r_seam_rd;
        end
    end

    // ---------------------------------------------------------------
    // second multiply stage and output register
    // ---------------------------------------------------------------
    logic                                 r_vld_m2;
    logic signed [RAD_W+2*NRM_W+1:0]      w_pxp, w_pzp;
    logic signed [RAD_W+2*NRM_W+2:0]      w_pxs, w_pzs;
    logic signed [RAD_W+NRM_W+1:0]        w_pys;
    logic signed [2*NRM_W-1:0]            w_nxs, w_nzs;

    t_pos r_pos_x, r_pos_y, r_pos_z;
    t_q14 r_nrm_x, r_nrm_y, r_nrm_z, r_tan_x, r_tan_z;
    t_tex r_tex_s, r_tex_t;
    logic r_seam;

    assign w_pxp = r_a * r_ct_m1;
    assign w_pzp = r_a * r_st_m1;
    assign w_pxs = (RAD_W+2*NRM_W+3)'(w_pxp) + ((RAD_W+2*NRM_W+3)'(1) <<< 27);
    assign w_pzs = (RAD_W+2*NRM_W+3)'(w_pzp) + ((RAD_W+2*NRM_W+3)'(1) <<< 27);
    assign w_pys = (RAD_W+NRM_W+2)'(r_pyp) + ((RAD_W+NRM_W+2)'(1) <<< 13);
    assign w_nxs = (2*NRM_W)'(r_ncx) + ((2*NRM_W)'(1) <<< 13);
    assign w_nzs = (2*NRM_W)'(r_ncz) + ((2*NRM_W)'(1) <<< 13);

    assign w_rdy_m2 = !r_vld_m2 || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m2 <= 1'b0;
        end else if (w_rdy_m2) begin
            r_vld_m2 <= r_vld_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld_m1 && w_rdy_m2) begin
            r_pos_x <= sat_pos(36'(w_pxs >>> 28));
            r_pos_y <= sat_pos(36'(w_pys >>> 14));
            r_pos_z <= sat_pos(36'(w_pzs >>> 28));
            r_nrm_x <= sat_q14(36'(w_nxs >>> 14));
            r_nrm_y <= r_sp_m1;
            r_nrm_z <= sat_q14(36'(w_nzs >>> 14));
            r_tan_x <= -r_st_m1;
            r_tan_z <= r_ct_m1;
            r_tex_s <= r_ta_m1;
            r_tex_t <= r_tb_m1;
            r_seam  <= r_seam_m1;
        end
    end

    assign o_out.valid     = r_vld_m2;
    assign o_out.pos_x     = r_pos_x;
    assign o_out.pos_y     = r_pos_y;
    assign o_out.pos_z     = r_pos_z;
    assign o_out.normal_x  = r_nrm_x;
    assign o_out.normal_y  = r_nrm_y;
    assign o_out.normal_z  = r_nrm_z;
    assign o_out.tangent_x = r_tan_x;
    assign o_out.tangent_z = r_tan_z;
    assign o_out.tex_s     = r_tex_s;
    assign o_out.tex_t     = r_tex_t;
    assign o_out.on_seam   = r_seam;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a texcoord of 1.0 only comes from an index on the seam
    `TVG_ASSERT_IMP(a_tex_s_seam, i_clk, i_rst_n, o_out.valid && (o_out.tex_s == TEX_ONE), o_out.on_seam, "tex_s at 1.0 without seam flag")
    `TVG_ASSERT_IMP(a_tex_t_seam, i_clk, i_rst_n, o_out.valid && (o_out.tex_t == TEX_ONE), o_out.on_seam, "tex_t at 1.0 without seam flag")
    // an empty clamp stage always takes a transaction
    `TVG_ASSERT_IMP(a_front_open, i_clk, i_rst_n, !r_vld_f, i_in.ready, "input stalled with empty clamp stage")
    // an accepted transaction lands in the clamp stage
    `TVG_ASSERT_NXT(a_front_load, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld_f, "accepted transaction lost at clamp stage")
endmodule
